/* rtl/imdt_pkg.sv */
// Package for the ICY metadata demux with stream-title extraction.
// Holds the result types, character constants and the title key table.
// No dependencies; every other file uses it through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package imdt_pkg;

  // Configuration port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_META_INTERVAL = '0;

  localparam int INTERVAL_W = 16;
  localparam int META_REM_W = 12;
  localparam int LEN_SHIFT  = 4;     // length byte counts 16-byte units

  // Title limits
  localparam int TITLE_MAX   = 255;
  localparam int TITLE_CNT_W = $clog2(TITLE_MAX + 1);

  // Key "StreamTitle='"
  localparam int KEY_LEN   = 13;
  localparam int KEY_POS_W = 4;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int MAX_RES   = 3;
  localparam int RES_CNT_W = 2;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_AUDIO = 2'b01,
    PH_META  = 2'b10
  } phase_e;

  typedef enum logic [2:0] {
    TS_SEARCH = 3'b001,
    TS_TITLE  = 3'b010,
    TS_DONE   = 3'b100
  } title_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } result_t;

  // Up to three results caused by one input byte
  typedef struct packed {
    result_t [MAX_RES-1:0] item;
    logic [RES_CNT_W-1:0]  count;
  } bundle_t;

  // Configuration view handed to the parser
  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic                  restart;
    logic [INTERVAL_W-1:0] new_interval;
  } cfg_t;

  function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (pos)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = CH_QUOTE;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/imdt_stream_if.sv */
// Stream channel interfaces: raw input bytes and demux results.
// Depends on imdt_pkg for the result kind type.
`timescale 1ns / 1ps
`default_nettype none

interface imdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface imdt_out_if;
  logic                valid;
  logic                ready;
  imdt_pkg::kind_e     kind;
  logic [7:0]          out_byte;
  logic                last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

/* rtl/imdt_apb_regs.sv */
// APB-style configuration register: the metadata interval.
// Depends on imdt_pkg; emits a restart request on every interval write.
`timescale 1ns / 1ps
`default_nettype none

module imdt_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [imdt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [imdt_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [imdt_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output imdt_pkg::cfg_t                       cfg_o
);

  logic [imdt_pkg::INTERVAL_W-1:0] interval_q, interval_d;
  logic [imdt_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            wr_en;
  logic                            hit_interval;

  assign pready  = 1'b1;
  assign reg_idx = paddr[imdt_pkg::APB_ADDR_W-1:2];

  always_comb begin
    hit_interval = 1'b0;
    unique case (reg_idx)
      imdt_pkg::REG_META_INTERVAL: hit_interval = 1'b1;
      default:                     hit_interval = 1'b0;
    endcase
  end

  assign wr_en      = psel && penable && pwrite && pready && hit_interval;
  assign interval_d = wr_en ? pwdata[imdt_pkg::INTERVAL_W-1:0] : interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else begin
      interval_q <= interval_d;
    end
  end

  assign prdata = hit_interval ?
                  {{(imdt_pkg::APB_DATA_W - imdt_pkg::INTERVAL_W){1'b0}}, interval_q} : '0;

  assign cfg_o.interval     = interval_q;
  assign cfg_o.restart      = wr_en;
  assign cfg_o.new_interval = pwdata[imdt_pkg::INTERVAL_W-1:0];

endmodule

`default_nettype wire

/* rtl/imdt_parser.sv */
// Demux state and title matcher: turns one accepted byte into a bundle of
// up to three results in a single pass. Depends on imdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imdt_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire imdt_pkg::cfg_t cfg_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  output imdt_pkg::bundle_t bundle_o
);

  imdt_pkg::phase_e                    ph_q, ph_d;
  logic [imdt_pkg::INTERVAL_W-1:0]     ac_q, ac_d;
  logic [imdt_pkg::META_REM_W-1:0]     mr_q, mr_d;
  logic [imdt_pkg::KEY_POS_W-1:0]      mp_q, mp_d;
  imdt_pkg::title_state_e              ts_q, ts_d;
  logic                                qp_q, qp_d;
  logic [imdt_pkg::TITLE_CNT_W-1:0]    tc_q, tc_d;
  imdt_pkg::bundle_t                   bnd;

  function automatic imdt_pkg::bundle_t push(input imdt_pkg::bundle_t b,
                                             input imdt_pkg::kind_e k,
                                             input logic [7:0] d);
    imdt_pkg::bundle_t r;
    r = b;
    r.item[b.count].kind     = k;
    r.item[b.count].out_byte = d;
    r.count                  = b.count + imdt_pkg::RES_CNT_W'(1);
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    b    = data_byte_i;
    ph_d = ph_q;
    ac_d = ac_q;
    mr_d = mr_q;
    mp_d = mp_q;
    ts_d = ts_q;
    qp_d = qp_q;
    tc_d = tc_q;
    bnd  = '0;

    if (cfg_i.interval == '0) begin
      bnd = push(bnd, imdt_pkg::KIND_AUDIO, b);
    end else if (ph_q == imdt_pkg::PH_AUDIO) begin
      if (ac_q != '0) begin
        ac_d = ac_q - imdt_pkg::INTERVAL_W'(1);
        bnd  = push(bnd, imdt_pkg::KIND_AUDIO, b);
      end else if (b == imdt_pkg::CH_NUL) begin
        // empty block: straight back to audio
        ac_d = cfg_i.interval;
      end else begin
        ph_d = imdt_pkg::PH_META;
        mr_d = {b, {imdt_pkg::LEN_SHIFT{1'b0}}};
        mp_d = '0;
        ts_d = imdt_pkg::TS_SEARCH;
        qp_d = 1'b0;
        tc_d = '0;
      end
    end else begin
      unique case (ts_q)
        imdt_pkg::TS_SEARCH: begin
          if (b == imdt_pkg::CH_NUL) begin
            ts_d = imdt_pkg::TS_DONE;
          end else if (mp_q < imdt_pkg::KEY_POS_W'(imdt_pkg::KEY_LEN) &&
                       b == imdt_pkg::key_char(mp_q)) begin
            mp_d = mp_q + imdt_pkg::KEY_POS_W'(1);
            if (mp_d == imdt_pkg::KEY_POS_W'(imdt_pkg::KEY_LEN)) begin
              ts_d = imdt_pkg::TS_TITLE;
              tc_d = '0;
              qp_d = 1'b0;
            end
          end else begin
            mp_d = (b == imdt_pkg::CH_S) ? imdt_pkg::KEY_POS_W'(1) : '0;
          end
        end
        imdt_pkg::TS_TITLE: begin
          if (qp_q && b == imdt_pkg::CH_SEMI) begin
            qp_d = 1'b0;
            ts_d = imdt_pkg::TS_DONE;
            bnd  = push(bnd, imdt_pkg::KIND_DONE, '0);
          end else begin
            // release a held quote that turned out to be title text
            if (qp_q) begin
              qp_d = 1'b0;
              if (tc_d < imdt_pkg::TITLE_CNT_W'(imdt_pkg::TITLE_MAX)) begin
                tc_d = tc_d + imdt_pkg::TITLE_CNT_W'(1);
                bnd  = push(bnd, imdt_pkg::KIND_TITLE, imdt_pkg::CH_QUOTE);
              end
            end
            if (b == imdt_pkg::CH_NUL) begin
              ts_d = imdt_pkg::TS_DONE;
              bnd  = push(bnd, imdt_pkg::KIND_DONE, '0);
            end else if (b == imdt_pkg::CH_QUOTE) begin
              qp_d = 1'b1;
            end else if (tc_d < imdt_pkg::TITLE_CNT_W'(imdt_pkg::TITLE_MAX)) begin
              tc_d = tc_d + imdt_pkg::TITLE_CNT_W'(1);
              bnd  = push(bnd, imdt_pkg::KIND_TITLE, b);
            end
          end
        end
        default: ;
      endcase

      if (mr_q != '0) begin
        mr_d = mr_q - imdt_pkg::META_REM_W'(1);
      end
      if (mr_d == '0) begin
        // block end closes an open title
        if (ts_d == imdt_pkg::TS_TITLE) begin
          if (qp_d) begin
            qp_d = 1'b0;
            if (tc_d < imdt_pkg::TITLE_CNT_W'(imdt_pkg::TITLE_MAX)) begin
              tc_d = tc_d + imdt_pkg::TITLE_CNT_W'(1);
              bnd  = push(bnd, imdt_pkg::KIND_TITLE, imdt_pkg::CH_QUOTE);
            end
          end
          ts_d = imdt_pkg::TS_DONE;
          bnd  = push(bnd, imdt_pkg::KIND_DONE, '0);
        end
        ph_d = imdt_pkg::PH_AUDIO;
        ac_d = cfg_i.interval;
      end
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= imdt_pkg::PH_AUDIO;
      ac_q <= '0;
      mr_q <= '0;
      mp_q <= '0;
      ts_q <= imdt_pkg::TS_SEARCH;
      qp_q <= 1'b0;
      tc_q <= '0;
    end else if (cfg_i.restart) begin
      ph_q <= imdt_pkg::PH_AUDIO;
      ac_q <= cfg_i.new_interval;
      mr_q <= '0;
      mp_q <= '0;
      ts_q <= imdt_pkg::TS_SEARCH;
      qp_q <= 1'b0;
      tc_q <= '0;
    end else if (accept_i) begin
      ph_q <= ph_d;
      ac_q <= ac_d;
      mr_q <= mr_d;
      mp_q <= mp_d;
      ts_q <= ts_d;
      qp_q <= qp_d;
      tc_q <= tc_d;
    end
  end

  a_title_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q <= imdt_pkg::TITLE_CNT_W'(imdt_pkg::TITLE_MAX))
    else $error("title count above limit");

  a_quote_in_title: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qp_q |-> ts_q == imdt_pkg::TS_TITLE)
    else $error("quote held outside a title");

  a_meta_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == imdt_pkg::PH_META |-> mr_q != '0)
    else $error("metadata phase with no bytes left");

endmodule

`default_nettype wire

/* rtl/imdt_out_buf.sv */
// Result register: holds one bundle and hands its results out one a cycle while the output is ready.
// Depends on imdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imdt_out_buf (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire imdt_pkg::bundle_t bundle_i,
  output logic              can_load_o,
  imdt_out_if.source        out
);

  imdt_pkg::result_t [imdt_pkg::MAX_RES-1:0] res_q;
  logic [imdt_pkg::RES_CNT_W-1:0]            cnt_q, cnt_d;
  logic [imdt_pkg::RES_CNT_W-1:0]            idx_q, idx_d;
  logic                                      take;

  assign take       = out.valid && out.ready;
  // free, or the final result leaves in this cycle
  assign can_load_o = (cnt_q == '0) ||
                      (cnt_q == imdt_pkg::RES_CNT_W'(1) && out.ready);

  assign out.valid    = cnt_q != '0;
  assign out.kind     = res_q[idx_q].kind;
  assign out.out_byte = res_q[idx_q].out_byte;
  assign out.last     = cnt_q == imdt_pkg::RES_CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.count;
      idx_d = '0;
    end else if (take) begin
      cnt_d = cnt_q - imdt_pkg::RES_CNT_W'(1);
      idx_d = idx_q + imdt_pkg::RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.item;
    end
  end

endmodule

`default_nettype wire

/* rtl/icy_metadata_demux_title.sv */
// ICY metadata demux: results appear in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte has at most one result
// and the output is ready; a byte with up to three results holds the output
// register until all leave. No-result bytes (length, metadata) add no stall.
// Reset (async, active low) clears the interval to zero (pass-through) and
// all parser state; no clearing pass, the input is ready straight out of reset.
`timescale 1ns / 1ps
`default_nettype none

module icy_metadata_demux_title (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [imdt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [imdt_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [imdt_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  // stream channels
  imdt_in_if.sink                              in_i,
  imdt_out_if.source                           out_o
);

  imdt_pkg::cfg_t    cfg;
  imdt_pkg::bundle_t bundle;
  logic              can_load;
  logic              accept;

  // Interval register; a write restarts the demux in audio phase.
  imdt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take a new request whenever the result register is free or drains now.
  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  // Single-pass parser: advance the demux state on every accepted byte.
  imdt_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .bundle_o    (bundle)
  );

  // Result register: hold the bundle, hand out one result per cycle while the output is ready.
  imdt_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .out        (out_o)
  );

endmodule

`default_nettype wire
